[design/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define RRPS_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define RRPS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

[design/rrps_pkg.sv]
`default_nettype none
package rrps_pkg;

	localparam int unsigned CoordW = 24;
	localparam int unsigned DirW   = 16;
	localparam int unsigned WidthW = 20;
	localparam int unsigned OutW   = 16;
	localparam int unsigned LimW   = 32;

	localparam logic CmdLoad    = 1'b0;
	localparam logic CmdAdvance = 1'b1;

	typedef struct packed {
		logic                     cmd;
		logic signed [CoordW-1:0] start_x;
		logic signed [CoordW-1:0] start_y;
		logic signed [CoordW-1:0] end_x;
		logic signed [CoordW-1:0] end_y;
		logic signed [DirW-1:0]   dir_cos;
		logic signed [DirW-1:0]   dir_sin;
		logic [WidthW-1:0]        rect_width;
	} in_item_t;

	typedef struct packed {
		logic signed [OutW-1:0] pixel_x;
		logic signed [OutW-1:0] pixel_y;
		logic                   finished;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROW,
		ST_EDGE_MUL,
		ST_EDGE_START,
		ST_EDGE_DIV,
		ST_EDGE_DONE,
		ST_EMIT
	} scan_state_t;

endpackage
`default_nettype wire

[design/rrps_front.sv]
`default_nettype none
// Accepts items, works out corner offsets and rotation, and queues them.
module rrps_front #(
	parameter int unsigned DIR_FRAC_BITS = 14
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  rrps_pkg::in_item_t     in_item,
	output logic                   q_valid,
	input  wire logic              q_take,
	output logic                   q_cmd,
	output logic signed [rrps_pkg::CoordW-1:0] q_cx [4],
	output logic signed [rrps_pkg::CoordW-1:0] q_cy [4]
);
	import rrps_pkg::*;

	localparam int unsigned ProdW = DirW + WidthW + 2;
	localparam int unsigned SumW  = CoordW + 2;

	// Stage 1: products registered.
	logic                     v_s1;
	logic                     cmd_s1;
	logic [1:0]               rot_s1;
	logic signed [CoordW-1:0] x1_s1, y1_s1, x2_s1, y2_s1;
	logic signed [ProdW-1:0]  ps_s1, pc_s1;

	// Two-entry queue to the back part.
	logic [1:0]               cnt_q;
	logic                     rd_q, wr_q;
	logic                     cmd_q [2];
	logic signed [CoordW-1:0] cx_q [2][4];
	logic signed [CoordW-1:0] cy_q [2][4];

	logic                     acc;
	logic [1:0]               rot_c;
	logic signed [ProdW-1:0]  offs, offc;
	logic signed [SumW-1:0]   bx [4];
	logic signed [SumW-1:0]   by [4];
	logic                     qpush;

	function automatic logic signed [CoordW-1:0] sat(input logic signed [SumW-1:0] v);
		logic signed [SumW-1:0] hi, lo;
		hi = SumW'((1 <<< (CoordW - 1)) - 1);
		lo = -SumW'(1 <<< (CoordW - 1));
		if (v > hi)
			return hi[CoordW-1:0];
		else if (v < lo)
			return lo[CoordW-1:0];
		return v[CoordW-1:0];
	endfunction

	// Stage 1 only accepts when the queue can take it after.
	assign full = v_s1 && (cnt_q == 2'd2);
	assign acc  = push && !full;

	always_comb begin
		if (in_item.start_x < in_item.end_x && in_item.start_y <= in_item.end_y)
			rot_c = 2'd0;
		else if (in_item.start_x >= in_item.end_x && in_item.start_y < in_item.end_y)
			rot_c = 2'd1;
		else if (in_item.start_x > in_item.end_x && in_item.start_y >= in_item.end_y)
			rot_c = 2'd2;
		else
			rot_c = 2'd3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (qpush) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1 <= in_item.cmd;
			rot_s1 <= rot_c;
			x1_s1  <= in_item.start_x;
			y1_s1  <= in_item.start_y;
			x2_s1  <= in_item.end_x;
			y2_s1  <= in_item.end_y;
			ps_s1  <= ProdW'(in_item.dir_sin) * $signed({1'b0, in_item.rect_width});
			pc_s1  <= ProdW'(in_item.dir_cos) * $signed({1'b0, in_item.rect_width});
		end
	end

	always_comb begin
		offs = (ps_s1 + ProdW'(1 <<< DIR_FRAC_BITS)) >>> (DIR_FRAC_BITS + 1);
		offc = (pc_s1 + ProdW'(1 <<< DIR_FRAC_BITS)) >>> (DIR_FRAC_BITS + 1);
		bx[0] = SumW'(x1_s1) - SumW'(offs); by[0] = SumW'(y1_s1) + SumW'(offc);
		bx[1] = SumW'(x2_s1) - SumW'(offs); by[1] = SumW'(y2_s1) + SumW'(offc);
		bx[2] = SumW'(x2_s1) + SumW'(offs); by[2] = SumW'(y2_s1) - SumW'(offc);
		bx[3] = SumW'(x1_s1) + SumW'(offs); by[3] = SumW'(y1_s1) - SumW'(offc);
	end

	assign qpush   = v_s1 && (cnt_q != 2'd2);
	assign q_valid = cnt_q != 2'd0;
	assign q_cmd   = cmd_q[rd_q];
	assign q_cx    = cx_q[rd_q];
	assign q_cy    = cy_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (qpush)
				wr_q <= ~wr_q;
			if (q_take && q_valid)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(qpush) - 2'(q_take && q_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (qpush) begin
			cmd_q[wr_q] <= cmd_s1;
			for (int n = 0; n < 4; n++) begin
				cx_q[wr_q][n] <= sat(bx[2'(n + int'(rot_s1))]);
				cy_q[wr_q][n] <= sat(by[2'(n + int'(rot_s1))]);
			end
		end
	end
endmodule
`default_nettype wire

[design/rrps_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle, floor semantics on signed values.
module rrps_div #(
	parameter int unsigned NW = 50,
	parameter int unsigned DW = 26
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [NW-1:0] num,
	input  wire logic signed [DW-1:0] den,
	output logic                      done,
	output logic signed [NW-1:0]      quo
);
	localparam int unsigned CW = $clog2(NW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] q_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] d_q;
	logic          neg_q;
	logic          done_q;

	logic [DW:0]   r_sh;
	logic [DW:0]   r_sub;
	logic          num_neg;
	logic [NW-1:0] n_abs;
	logic [DW-1:0] d_abs;

	always_comb begin
		num_neg = num[NW-1] ^ den[DW-1];
		n_abs   = num[NW-1] ? NW'(-num) : NW'(num);
		d_abs   = den[DW-1] ? DW'(-den) : DW'(den);
		r_sh    = {r_q[DW-1:0], n_q[NW-1]};
		r_sub   = r_sh - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n_abs;
			d_q   <= d_abs;
			r_q   <= '0;
			q_q   <= '0;
			neg_q <= num_neg && (num != '0);
		end else if (busy_q) begin
			n_q <= {n_q[NW-2:0], 1'b0};
			if (!r_sub[DW]) begin
				r_q <= r_sub;
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	// Floor: a negative quotient with a remainder rounds down one more.
	assign quo  = neg_q ? (-$signed(q_q) - NW'(r_q != '0)) : $signed(q_q);
endmodule
`default_nettype wire

[design/rrps_back.sv]
`default_nettype none
// Scan sequencer: holds the rectangle and steps through its pixels.
module rrps_back #(
	parameter int unsigned COORD_FRAC_BITS = 8,
	parameter int unsigned PIXEL_BITS      = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           q_valid,
	output logic                                q_take,
	input  wire logic                           q_cmd,
	input  wire logic signed [rrps_pkg::CoordW-1:0] q_cx [4],
	input  wire logic signed [rrps_pkg::CoordW-1:0] q_cy [4],
	output logic                                empty,
	input  wire logic                           pop,
	output rrps_pkg::out_item_t                 out_item
);
	import rrps_pkg::*;

	localparam int unsigned PW  = CoordW - COORD_FRAC_BITS + 3;
	localparam int unsigned XW  = PW + COORD_FRAC_BITS + 1;
	localparam int unsigned DW  = CoordW + 2;
	localparam int unsigned NW  = XW + DW + 1;
	localparam int unsigned EW  = NW + 1;

	scan_state_t state_q, state_d;

	logic signed [CoordW-1:0] cx_q [4];
	logic signed [CoordW-1:0] cy_q [4];
	logic signed [PW-1:0]     col_q, row_q;
	logic signed [LimW-1:0]   lo_q, hi_q;
	logic                     side_q;
	logic signed [NW-1:0]     num_q;
	logic signed [DW-1:0]     den_q;
	logic signed [CoordW-1:0] y1_q, y2_q;
	logic                     vert_q;
	logic                     ovalid_q;
	out_item_t                oitem_q;

	logic signed [XW-1:0]     col_x, colp_x;
	logic signed [LimW:0]     row_x;
	logic                     past_hi;
	logic                     in_range, nxt_in;
	logic signed [PW-1:0]     ld_col;
	logic                     ld_in;
	logic [1:0]               ea, eb;
	logic                     div_start, div_done;
	logic signed [NW-1:0]     div_quo;
	logic signed [EW-1:0]     ev;
	logic signed [LimW-1:0]   ev_sat;
	logic                     do_emit;

	rrps_div #(.NW(NW), .DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num_q), .den(den_q), .done(div_done), .quo(div_quo)
	);

	function automatic logic signed [PW-1:0] ceilq(input logic signed [LimW-1:0] v);
		logic signed [LimW:0] s;
		s = (LimW+1)'(v) + (LimW+1)'((1 << COORD_FRAC_BITS) - 1);
		return PW'(s >>> COORD_FRAC_BITS);
	endfunction

	assign col_x    = XW'(col_q) <<< COORD_FRAC_BITS;
	assign colp_x   = XW'(col_q + PW'(1)) <<< COORD_FRAC_BITS;
	assign row_x    = (LimW+1)'(row_q) <<< COORD_FRAC_BITS;
	assign past_hi  = row_x > (LimW+1)'(hi_q);
	assign in_range = col_x <= XW'(cx_q[2]);
	assign nxt_in   = colp_x <= XW'(cx_q[2]);

	// The first step after a load only moves the row when the start column is in range.
	assign ld_col = ceilq(LimW'(cx_q[0])) - PW'(1);
	assign ld_in  = (XW'(ld_col) <<< COORD_FRAC_BITS) <= XW'(cx_q[2]);

	// side_q 0: low edge, 1: high edge.
	always_comb begin
		if (!side_q) begin
			ea = (colp_x < XW'(cx_q[3])) ? 2'd0 : 2'd3;
			eb = (colp_x < XW'(cx_q[3])) ? 2'd3 : 2'd2;
		end else begin
			ea = (colp_x < XW'(cx_q[1])) ? 2'd0 : 2'd1;
			eb = (colp_x < XW'(cx_q[1])) ? 2'd1 : 2'd2;
		end
	end

	always_comb begin
		ev = EW'(y1_q) + EW'(div_quo);
		if (vert_q) begin
			if (y1_q == y2_q)
				ev_sat = LimW'(y1_q);
			else if ((y1_q < y2_q) != side_q)
				ev_sat = LimW'(y1_q);
			else
				ev_sat = LimW'(y2_q);
		end else if (ev > EW'(32'sh7fffffff))
			ev_sat = 32'sh7fffffff;
		else if (ev < -EW'(64'sh80000000))
			ev_sat = 32'sh80000000;
		else
			ev_sat = ev[LimW-1:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (q_valid && !ovalid_q)
					state_d = (q_cmd == CmdLoad) ? ST_LOAD : ST_ROW;
			ST_LOAD:
				state_d = ST_ROW;
			ST_ROW:
				if (in_range && past_hi && nxt_in)
					state_d = ST_EDGE_MUL;
				else
					state_d = ST_EMIT;
			ST_EDGE_MUL:
				state_d = ST_EDGE_START;
			ST_EDGE_START:
				state_d = vert_q ? ST_EDGE_DONE : ST_EDGE_DIV;
			ST_EDGE_DIV:
				if (div_done)
					state_d = ST_EDGE_DONE;
			ST_EDGE_DONE:
				state_d = side_q ? ST_ROW : ST_EDGE_MUL;
			ST_EMIT:
				state_d = ST_IDLE;
			default:
				state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_take    = (state_q == ST_IDLE) && q_valid && !ovalid_q;
		div_start = (state_q == ST_EDGE_START) && !vert_q;
		do_emit   = state_q == ST_EMIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			side_q   <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
			lo_q     <= 32'sh80000000;
			hi_q     <= 32'sh80000000;
			for (int n = 0; n < 4; n++) begin
				cx_q[n] <= '0;
				cy_q[n] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (do_emit)
				ovalid_q <= 1'b1;
			else if (pop)
				ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE:
					if (q_take && q_cmd == CmdLoad) begin
						cx_q <= q_cx;
						cy_q <= q_cy;
					end else if (q_take && in_range) begin
						row_q <= row_q + PW'(1);
					end
				ST_LOAD: begin
					col_q <= ld_col;
					row_q <= ceilq(LimW'(cy_q[0])) + PW'(ld_in);
					lo_q  <= 32'sh80000000;
					hi_q  <= 32'sh80000000;
				end
				ST_EDGE_DONE:
					if (!side_q) begin
						lo_q   <= ev_sat;
						side_q <= 1'b1;
					end else begin
						hi_q   <= ev_sat;
						side_q <= 1'b0;
						col_q  <= col_q + PW'(1);
						row_q  <= ceilq(lo_q);
					end
				ST_ROW:
					if (in_range && past_hi && !nxt_in)
						col_q <= col_q + PW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EDGE_MUL) begin
			vert_q <= cx_q[ea] == cx_q[eb];
			y1_q   <= cy_q[ea];
			y2_q   <= cy_q[eb];
			num_q  <= NW'(colp_x - XW'(cx_q[ea])) * NW'(DW'(cy_q[eb]) - DW'(cy_q[ea]));
			den_q  <= DW'(cx_q[eb]) - DW'(cx_q[ea]);
		end
		if (do_emit) begin
			oitem_q.finished <= !in_range;
			oitem_q.pixel_x  <= in_range ? OutW'(PIXEL_BITS'(col_q)) : '0;
			oitem_q.pixel_y  <= in_range ? OutW'(PIXEL_BITS'(row_q)) : '0;
		end
	end

	assign empty    = !ovalid_q;
	assign out_item = oitem_q;
endmodule
`default_nettype wire

[design/rotated_rect_pixel_scan_top.sv]
`default_nettype none
`include "assert_macros.svh"
// Rotated rectangle pixel scanner. A load item (cmd 0) builds the four
// corners of the rectangle and returns its first covered pixel; each advance
// item (cmd 1) returns the next pixel, row by row inside a column, then
// column by column. A result with finished set means the scan has passed
// the rightmost corner. Items enter through a two-stage front that computes
// corner offsets and queues two items; the back sequencer then handles one
// item at a time. A pixel inside the same column passes stage 1, the queue
// and the back states IDLE, ROW and EMIT before its result is registered; a
// load adds the LOAD state. The back takes a new item only once the last
// result has been read. A column change evaluates the lower and then the
// upper edge line on a shared bit-serial divider. A sloped edge runs setup,
// start, the divider and store; a vertical edge skips the divider, and the
// divider limits how fast the scan changes column.
module rotated_rect_pixel_scan_top #(
	parameter int unsigned COORD_FRAC_BITS = 8,
	parameter int unsigned PIXEL_BITS      = 16,
	parameter int unsigned DIR_FRAC_BITS   = 14
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  rrps_pkg::in_item_t      in_item,
	output logic                    empty,
	input  wire logic               pop,
	output rrps_pkg::out_item_t     out_item
);
	import rrps_pkg::*;

	logic                     q_valid, q_take, q_cmd;
	logic signed [CoordW-1:0] q_cx [4];
	logic signed [CoordW-1:0] q_cy [4];

	// The front accepts and queues items while the back is busy scanning.
	rrps_front #(.DIR_FRAC_BITS(DIR_FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd), .q_cx(q_cx), .q_cy(q_cy)
	);

	// The back walks the pixels and holds one finished result for the reader.
	rrps_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .PIXEL_BITS(PIXEL_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_take(q_take),
		.q_cmd(q_cmd), .q_cx(q_cx), .q_cy(q_cy), .empty(empty), .pop(pop),
		.out_item(out_item)
	);

	// The back never takes from an empty queue.
	`RRPS_ASSERT_IMP(a_take_valid, clk, arst_n, q_take, q_valid)
	// A finished result carries a zero pixel.
	`RRPS_ASSERT_IMP(a_fin_zero, clk, arst_n, !empty && out_item.finished,
		out_item.pixel_x == '0 && out_item.pixel_y == '0)
	// A result left unread stays visible in the next cycle.
	`RRPS_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty)
endmodule
`default_nettype wire

[tb/tb_rotated_rect_pixel_scan_top.sv]
`default_nettype none
module tb_rotated_rect_pixel_scan_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rrps_pkg::*;

	localparam longint CoordMax = 64'sd8388607;
	localparam longint CoordMin = -64'sd8388608;
	localparam longint LimMax   = 64'sd2147483647;
	localparam longint LimMin   = -64'sd2147483648;
	localparam real    Pi       = 3.14159265358979;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      pop = 1'b0;
	logic      full;
	logic      empty;
	in_item_t  in_item = '0;
	out_item_t out_item;

	// When set, neither side inserts idle cycles.
	bit no_idle = 1'b0;

	out_item_t pending_pixels[$];
	int        mismatch_count = 0;
	int        item_count = 0;
	int        load_count = 0;
	int        pixel_count = 0;
	int        finished_count = 0;

	// Shadow copy of the scanner state, kept at full precision.
	longint corner_x[4];
	longint corner_y[4];
	longint scan_col;
	longint scan_row;
	longint row_lo;
	longint row_hi;

	rotated_rect_pixel_scan_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.in_item (in_item),
		.empty   (empty),
		.pop     (pop),
		.out_item(out_item)
	);

	always #5 clk = ~clk;

	function automatic longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint floor_div(longint num, longint den);
		longint q;
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q = q - 1;
		return q;
	endfunction

	// The arithmetic shift of a signed value rounds toward minus infinity.
	function automatic longint ceil_q8(longint v);
		return (v + 255) >>> 8;
	endfunction

	// Height of the edge from corner a to corner b at column position x (Q8).
	// A vertical edge gives its lower or upper end point.
	function automatic longint edge_height(bit lower, longint x, int a, int b);
		longint x1, y1, x2, y2;
		x1 = corner_x[a];
		y1 = corner_y[a];
		x2 = corner_x[b];
		y2 = corner_y[b];
		if (x1 == x2) begin
			if (y1 < y2)
				return lower ? y1 : y2;
			if (y1 > y2)
				return lower ? y2 : y1;
			return y1;
		end
		return clamp(y1 + floor_div((x - x1) * (y2 - y1), x2 - x1), LimMin, LimMax);
	endfunction

	function automatic void step_scan();
		longint x;
		if ((scan_col <<< 8) <= corner_x[2])
			scan_row++;
		while ((scan_row <<< 8) > row_hi && (scan_col <<< 8) <= corner_x[2]) begin
			scan_col++;
			x = scan_col <<< 8;
			if (x > corner_x[2])
				return;
			row_lo = (x < corner_x[3]) ? edge_height(1'b1, x, 0, 3)
			                           : edge_height(1'b1, x, 3, 2);
			row_hi = (x < corner_x[1]) ? edge_height(1'b0, x, 0, 1)
			                           : edge_height(1'b0, x, 1, 2);
			scan_row = ceil_q8(row_lo);
		end
	endfunction

	function automatic out_item_t next_pixel(in_item_t it);
		longint x1, y1, x2, y2, dc, ds, w, off_s, off_c;
		longint bx[4], by[4];
		int rot;
		out_item_t r;
		if (it.cmd == CmdLoad) begin
			x1 = $signed(it.start_x);
			y1 = $signed(it.start_y);
			x2 = $signed(it.end_x);
			y2 = $signed(it.end_y);
			dc = $signed(it.dir_cos);
			ds = $signed(it.dir_sin);
			w = it.rect_width;
			off_s = (ds * w + 16384) >>> 15;
			off_c = (dc * w + 16384) >>> 15;
			bx[0] = x1 - off_s; by[0] = y1 + off_c;
			bx[1] = x2 - off_s; by[1] = y2 + off_c;
			bx[2] = x2 + off_s; by[2] = y2 - off_c;
			bx[3] = x1 + off_s; by[3] = y1 - off_c;
			if (x1 < x2 && y1 <= y2)
				rot = 0;
			else if (x1 >= x2 && y1 < y2)
				rot = 1;
			else if (x1 > x2 && y1 >= y2)
				rot = 2;
			else
				rot = 3;
			for (int n = 0; n < 4; n++) begin
				corner_x[n] = clamp(bx[(n + rot) % 4], CoordMin, CoordMax);
				corner_y[n] = clamp(by[(n + rot) % 4], CoordMin, CoordMax);
			end
			scan_col = ceil_q8(corner_x[0]) - 1;
			scan_row = ceil_q8(corner_y[0]);
			row_lo = LimMin;
			row_hi = LimMin;
		end
		step_scan();
		r.finished = (scan_col <<< 8) > corner_x[2];
		r.pixel_x = r.finished ? '0 : scan_col[OutW-1:0];
		r.pixel_y = r.finished ? '0 : scan_row[OutW-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatch_count++;
		$display("MISMATCH %s: got %0d, expected %0d (pixel %0d)", what, got, want,
		         pixel_count);
	endtask

	// Sends one item. The push line is left high after acceptance, so the next
	// call either keeps it high with new contents or drops it for idle cycles.
	task automatic send_item(in_item_t it);
		while (!no_idle && $urandom_range(99) < 27) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		in_item <= it;
		do
			@(posedge clk);
		while (full);
		pending_pixels.push_back(next_pixel(it));
		item_count++;
		if (it.cmd == CmdLoad)
			load_count++;
	endtask

	function automatic in_item_t load_item(longint sx, longint sy, longint ex, longint ey,
	                                       longint dc, longint ds, longint w);
		in_item_t it;
		it.cmd = CmdLoad;
		it.start_x = CoordW'(clamp(sx, CoordMin, CoordMax));
		it.start_y = CoordW'(clamp(sy, CoordMin, CoordMax));
		it.end_x = CoordW'(clamp(ex, CoordMin, CoordMax));
		it.end_y = CoordW'(clamp(ey, CoordMin, CoordMax));
		it.dir_cos = DirW'(dc);
		it.dir_sin = DirW'(ds);
		it.rect_width = WidthW'(w);
		return it;
	endfunction

	// An advance carries random geometry that the block must ignore.
	function automatic in_item_t advance_item();
		in_item_t it;
		it = $bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
		it.cmd = CmdAdvance;
		return it;
	endfunction

	task automatic send_advances(int count);
		repeat (count) send_item(advance_item());
	endtask

	// Results are checked at the edge that accepts them; pop is redrawn
	// after it has been sampled.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				if (out_item.pixel_x !== pending_pixels[0].pixel_x)
					report_mismatch("pixel_x", out_item.pixel_x, pending_pixels[0].pixel_x);
				if (out_item.pixel_y !== pending_pixels[0].pixel_y)
					report_mismatch("pixel_y", out_item.pixel_y, pending_pixels[0].pixel_y);
				if (out_item.finished !== pending_pixels[0].finished)
					report_mismatch("finished", out_item.finished,
					                pending_pixels[0].finished);
				if (pending_pixels[0].finished)
					finished_count++;
				void'(pending_pixels.pop_front());
			end
			pixel_count++;
		end
		pop <= arst_n && (no_idle || $urandom_range(99) >= 27);
	end

	// With no load yet, the scan runs on the all-zero corners and finishes.
	task automatic test_advance_before_load();
		send_advances(2);
	endtask

	// Field extremes: the widest rectangle, both ends of the coordinate range,
	// full positive and negative direction components.
	task automatic test_field_extremes();
		send_item(load_item(0, 0, 512, 0, 16384, 0, 20'hFFFFF));
		send_advances(3);
		send_item(load_item(CoordMax - 512, CoordMax - 512, CoordMax, CoordMax,
		                    11585, 11585, 1024));
		send_advances(3);
		send_item(load_item(CoordMin + 768, CoordMin, CoordMin, CoordMin, -16384, 0, 1024));
		send_advances(3);
		send_item(load_item(CoordMax - 300, 0, CoordMax, 0, 16384, 0, 2048));
		send_advances(2);
	endtask

	// Axis-aligned directions give vertical edges; a zero width collapses
	// the edge to a single point in height.
	task automatic test_vertical_edges();
		send_item(load_item(0, 1000, 0, 0, 0, -16384, 512));
		send_advances(3);
		send_item(load_item(256, 256, 256, 1024, 0, 16384, 0));
		send_advances(3);
	endtask

	// A direction that disagrees with the end points gives reversed edges.
	task automatic test_reversed_edges();
		send_item(load_item(0, 0, 1024, 512, -11585, 11585, 900));
		send_advances(2);
	endtask

	// A tiny rectangle runs out quickly; advances past the end stay finished.
	task automatic test_finished_tail();
		send_item(load_item(100, 100, 600, 100, 16384, 0, 300));
		send_advances(14);
	endtask

	// Mostly well-formed rectangles with random size and angle, scanned for a
	// random number of pixels; one in ten has a random direction instead.
	task automatic test_random_scans(int target);
		longint sx, sy, len, w, dc, ds;
		real ang;
		int done;
		done = 0;
		while (done < target) begin
			no_idle = (done >= 300 && done < 450);
			if ($urandom_range(4) == 0) begin
				sx = $signed($urandom_range(16777215) - 8388608);
				sy = $signed($urandom_range(16777215) - 8388608);
			end else begin
				sx = $signed($urandom_range(10000)) - 5000;
				sy = $signed($urandom_range(10000)) - 5000;
			end
			len = $urandom_range(3000);
			w = $urandom_range(3000);
			if ($urandom_range(9) == 0) begin
				dc = $signed($urandom_range(32768)) - 16384;
				ds = $signed($urandom_range(32768)) - 16384;
				send_item(load_item(sx, sy, sx + $signed($urandom_range(6000)) - 3000,
				                    sy + $signed($urandom_range(6000)) - 3000, dc, ds, w));
			end else begin
				ang = $urandom_range(3599) * Pi / 1800.0;
				dc = $rtoi($floor(16384.0 * $cos(ang) + 0.5));
				ds = $rtoi($floor(16384.0 * $sin(ang) + 0.5));
				send_item(load_item(sx, sy, sx + $rtoi(len * $cos(ang)),
				                    sy + $rtoi(len * $sin(ang)), dc, ds, w));
			end
			done++;
			repeat ($urandom_range(35)) begin
				send_item(advance_item());
				done++;
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_advance_before_load();
		test_field_extremes();
		test_vertical_edges();
		test_reversed_edges();
		test_finished_tail();
		test_random_scans(950);
		push <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		$display("Sent %0d items (%0d loads); checked %0d pixels, %0d of them finished.",
		         item_count, load_count, pixel_count, finished_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#200ms;
		$display("Timed out with %0d results outstanding.", pending_pixels.size());
		$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire
